// ===== hdl/ufn_pkg.sv =====
// ufn_pkg: shared constants and the pipeline control struct of the unit face normal block
// no dependencies
`default_nettype none
package ufn_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int NORMAL_WIDTH = 16;

    // control that travels with each request through the pipeline
    typedef struct packed {
        logic       valid;
        logic       deg;
        logic [2:0] neg;
    } ctl_t;

endpackage
`default_nettype wire

// ===== hdl/ufn_div_stage.sv =====
// ufn_div_stage: one bit of the rounded normalize search, for all three components
// depends on ufn_pkg (ctl_t)
`default_nettype none
module ufn_div_stage #(
    parameter int SW = 64,
    parameter int BW = 94,
    parameter int VW = 96,
    parameter int QW = 15,
    parameter int K  = 0
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire ufn_pkg::ctl_t         ctl_in,
    input  wire logic [SW-1:0]         s_in,
    input  wire logic [BW-1:0]         t_in [3],
    input  wire logic [BW-1:0]         z_in [3],
    input  wire logic signed [VW-1:0]  v_in [3],
    input  wire logic [QW-1:0]         q_in [3],
    output ufn_pkg::ctl_t              ctl_out,
    output logic [SW-1:0]              s_out,
    output logic [BW-1:0]              t_out [3],
    output logic [BW-1:0]              z_out [3],
    output logic signed [VW-1:0]       v_out [3],
    output logic [QW-1:0]              q_out [3]
);

    ufn_pkg::ctl_t          ctl_reg;
    logic [SW-1:0]          s_reg;
    logic [BW-1:0]          t_reg [3];
    logic [BW-1:0]          z_reg [3];
    logic signed [VW-1:0]   v_reg [3];
    logic [QW-1:0]          q_reg [3];

    logic [BW-1:0]          z_next [3];
    logic signed [VW-1:0]   v_next [3];
    logic [QW-1:0]          q_next [3];

    logic signed [VW-1:0]   s_ext;
    logic signed [VW-1:0]   vs [3];
    logic signed [VW-1:0]   lhs [3];
    logic                   pass [3];

    assign s_ext = $signed({{(VW-SW){1'b0}}, s_in});

    // trial bit: (2q'-1)^2*S = Z + ((V + S<<K) << (K+2)), kept if within bound
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vs[i]   = v_in[i] + (s_ext <<< K);
            lhs[i]  = $signed({{(VW-BW){1'b0}}, z_in[i]}) + (vs[i] <<< (K + 2));
            pass[i] = lhs[i] <= $signed({{(VW-BW){1'b0}}, t_in[i]});
            if (pass[i]) begin
                z_next[i] = lhs[i][BW-1:0];
                v_next[i] = vs[i] + (s_ext <<< K);
                q_next[i] = q_in[i] | (QW'(1) << K);
            end else begin
                z_next[i] = z_in[i];
                v_next[i] = v_in[i];
                q_next[i] = q_in[i];
            end
        end
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg <= s_in;
            for (int i = 0; i < 3; i++) begin
                t_reg[i] <= t_in[i];
                z_reg[i] <= z_next[i];
                v_reg[i] <= v_next[i];
                q_reg[i] <= q_next[i];
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign s_out   = s_reg;
    assign t_out   = t_reg;
    assign z_out   = z_reg;
    assign v_out   = v_reg;
    assign q_out   = q_reg;

endmodule
`default_nettype wire

// ===== hdl/unit_face_normal_unit.sv =====
// unit_face_normal_unit: top level, cross product, squared length and rounded normalize pipeline
// depends on ufn_pkg and ufn_div_stage
//
//   channel  | direction | handshake          | payload
//   s_       | in        | s_valid / s_ready  | edge_a_x/y/z, edge_b_x/y/z
//   m_       | out       | m_valid / m_ready  | normal_x/y/z, degenerate
//
// one request per cycle unless a stall on m_ready holds the pipeline; four front stages for
// products, magnitudes, squares and the length sum, one stage per result bit, one output stage
// reset clears the valid bits of every stage; payload registers are not reset
// a stall on m_ready freezes every stage at once, s_ready follows
`default_nettype none
module unit_face_normal_unit #(
    parameter int COORD_WIDTH  = ufn_pkg::COORD_WIDTH,
    parameter int NORMAL_WIDTH = ufn_pkg::NORMAL_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [COORD_WIDTH-1:0]  s_edge_a_x,
    input  wire logic signed [COORD_WIDTH-1:0]  s_edge_a_y,
    input  wire logic signed [COORD_WIDTH-1:0]  s_edge_a_z,
    input  wire logic signed [COORD_WIDTH-1:0]  s_edge_b_x,
    input  wire logic signed [COORD_WIDTH-1:0]  s_edge_b_y,
    input  wire logic signed [COORD_WIDTH-1:0]  s_edge_b_z,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [NORMAL_WIDTH-1:0]      m_normal_x,
    output logic signed [NORMAL_WIDTH-1:0]      m_normal_y,
    output logic signed [NORMAL_WIDTH-1:0]      m_normal_z,
    output logic                                m_degenerate
);

    localparam int CW = COORD_WIDTH;
    localparam int NW = NORMAL_WIDTH;
    localparam int F  = NW - 2;
    localparam int QW = F + 1;
    localparam int PW = 2 * CW;
    localparam int SW = 4 * CW;
    localparam int BW = SW + 2 * F + 4;
    localparam int VW = BW + 2;
    localparam int NS = F + 1;

    logic en;

    // stage 1: six products
    logic                 p_valid_reg;
    logic signed [PW-1:0] pl_reg [3];
    logic signed [PW-1:0] pr_reg [3];

    // stage 2: cross product magnitude and sign
    logic                 c_valid_reg;
    logic [PW-1:0]        m_reg [3];
    logic [2:0]           neg_reg;
    logic signed [PW:0]   diff [3];
    logic [PW-1:0]        mag_next [3];
    logic [2:0]           neg_next;

    // stage 3: squares
    logic                 q_valid_reg;
    logic [SW-1:0]        sq_reg [3];
    logic [2:0]           neg3_reg;
    logic                 deg3_reg;

    // stage 4: squared length and bounds
    ufn_pkg::ctl_t        ctl4_reg;
    logic [SW-1:0]        s4_reg;
    logic [BW-1:0]        t4_reg [3];
    logic [BW-1:0]        z4 [3];
    logic signed [VW-1:0] v4 [3];
    logic [QW-1:0]        q4 [3];

    // search stages
    ufn_pkg::ctl_t        ctl_st [NS+1];
    logic [SW-1:0]        s_st [NS+1];
    logic [BW-1:0]        t_st [NS+1][3];
    logic [BW-1:0]        z_st [NS+1][3];
    logic signed [VW-1:0] v_st [NS+1][3];
    logic [QW-1:0]        q_st [NS+1][3];

    // output stage
    logic                 out_valid_reg;
    logic signed [NW-1:0] nrm_reg [3];
    logic                 deg_reg;
    logic signed [NW-1:0] nrm_next [3];

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            ctl4_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg       <= s_valid;
            c_valid_reg       <= p_valid_reg;
            q_valid_reg       <= c_valid_reg;
            ctl4_reg.valid    <= q_valid_reg;
            ctl4_reg.deg      <= deg3_reg;
            ctl4_reg.neg      <= neg3_reg;
            out_valid_reg     <= ctl_st[NS].valid;
        end
    end

    // cross product terms: x = ay*bz - az*by, y = az*bx - ax*bz, z = ax*by - ay*bx
    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg[0] <= s_edge_a_y * s_edge_b_z;
            pr_reg[0] <= s_edge_a_z * s_edge_b_y;
            pl_reg[1] <= s_edge_a_z * s_edge_b_x;
            pr_reg[1] <= s_edge_a_x * s_edge_b_z;
            pl_reg[2] <= s_edge_a_x * s_edge_b_y;
            pr_reg[2] <= s_edge_a_y * s_edge_b_x;
        end
    end

    // difference to sign and magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i]     = {pl_reg[i][PW-1], pl_reg[i]} - {pr_reg[i][PW-1], pr_reg[i]};
            neg_next[i] = diff[i][PW];
            mag_next[i] = neg_next[i] ? PW'(-diff[i]) : diff[i][PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                m_reg[i] <= mag_next[i];
            end
            neg_reg <= neg_next;
        end
    end

    // squares and zero check
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= m_reg[i] * m_reg[i];
            end
            neg3_reg <= neg_reg;
            deg3_reg <= (m_reg[0] == '0) && (m_reg[1] == '0) && (m_reg[2] == '0);
        end
    end

    // squared length and per-component bound 4*c^2*2^(2F)
    always_ff @(posedge aclk) begin
        if (en) begin
            s4_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            for (int i = 0; i < 3; i++) begin
                t4_reg[i] <= BW'(sq_reg[i]) << (2 * F + 2);
            end
        end
    end

    // search start: q = 0, Z = S, V = -S
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            z4[i] = BW'(s4_reg);
            v4[i] = -$signed({{(VW-SW){1'b0}}, s4_reg});
            q4[i] = '0;
        end
    end

    assign ctl_st[0] = ctl4_reg;
    assign s_st[0]   = s4_reg;
    assign t_st[0]   = t4_reg;
    assign z_st[0]   = z4;
    assign v_st[0]   = v4;
    assign q_st[0]   = q4;

    // one result bit per stage, most significant first
    for (genvar j = 0; j < NS; j++) begin : g_stage
        ufn_div_stage #(
            .SW (SW),
            .BW (BW),
            .VW (VW),
            .QW (QW),
            .K  (F - j)
        ) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl_st[j]),
            .s_in    (s_st[j]),
            .t_in    (t_st[j]),
            .z_in    (z_st[j]),
            .v_in    (v_st[j]),
            .q_in    (q_st[j]),
            .ctl_out (ctl_st[j+1]),
            .s_out   (s_st[j+1]),
            .t_out   (t_st[j+1]),
            .z_out   (z_st[j+1]),
            .v_out   (v_st[j+1]),
            .q_out   (q_st[j+1])
        );
    end

    // sign and zero vector
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (ctl_st[NS].deg) begin
                nrm_next[i] = '0;
            end else if (ctl_st[NS].neg[i]) begin
                nrm_next[i] = -$signed(NW'(q_st[NS][i]));
            end else begin
                nrm_next[i] = $signed(NW'(q_st[NS][i]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nrm_reg <= nrm_next;
            deg_reg <= ctl_st[NS].deg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_normal_x   = nrm_reg[0];
    assign m_normal_y   = nrm_reg[1];
    assign m_normal_z   = nrm_reg[2];
    assign m_degenerate = deg_reg;

`ifndef NO_ASSERTIONS
    localparam logic signed [NW-1:0] ONE_Q = NW'(1) << F;

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |->
            (m_normal_x == '0) && (m_normal_y == '0) && (m_normal_z == '0))
        else $error("degenerate result with nonzero normal");

    a_nondeg_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |->
            (m_normal_x != '0) || (m_normal_y != '0) || (m_normal_z != '0))
        else $error("nondegenerate result with zero normal");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_x <= ONE_Q) && (m_normal_x >= -ONE_Q)
                 && (m_normal_y <= ONE_Q) && (m_normal_y >= -ONE_Q)
                 && (m_normal_z <= ONE_Q) && (m_normal_z >= -ONE_Q))
        else $error("normal component out of unit range");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> p_valid_reg)
        else $error("accepted request lost at first stage");
`endif

endmodule
`default_nettype wire
